[rtl/core/acd_pkg.sv]
// Shared types, constants and helper functions of the AT command line decoder.
package acd_pkg;

  // Default sizes of the line store and of the command split
  localparam int LINE_BYTES_DEF  = 20;
  localparam int BODY_MAX_DEF    = 12;
  localparam int OPTIONS_MAX_DEF = 6;

  // Option bytes that the commands look at
  localparam int NOPT = 5;

  // Register reset values and indexes
  localparam logic [6:0] HOST_ID_RST      = 7'd1;
  localparam logic [6:0] REMOTE_COUNT_RST = 7'd4;
  localparam logic       REG_HOST_ID      = 1'b0;
  localparam logic       REG_REMOTE_COUNT = 1'b1;

  // Character codes
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_F     = 8'h46;

  // Command names, right aligned, first character in the upper byte
  localparam int KW_BITS = 80;
  localparam logic [KW_BITS-1:0] KW_ON      = "at+on";
  localparam logic [KW_BITS-1:0] KW_OFF     = "at+off";
  localparam logic [KW_BITS-1:0] KW_VERSION = "at+version";
  localparam logic [KW_BITS-1:0] KW_SEMREG  = "at+semreg";
  localparam int KW_ON_LEN      = 5;
  localparam int KW_OFF_LEN     = 6;
  localparam int KW_VERSION_LEN = 10;
  localparam int KW_SEMREG_LEN  = 9;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_FWD     = 3'd0,
    KIND_VERSION = 3'd1,
    KIND_WR_OK   = 3'd2,
    KIND_RD      = 3'd3,
    KIND_WR_REJ  = 3'd4
  } kind_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EMIT,
    ST_FWD
  } state_t;

  // Outcome of decoding a finished line
  typedef struct packed {
    logic       cmd;      // a command result is to be sent
    kind_t      kind;
    logic [7:0] data;
    logic [6:0] addr;
    logic       set_sup;  // version or semreg seen
    logic       clr_sup;  // matching on/off seen
  } dec_t;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || ((c >= CH_A) && (c <= CH_F));
  endfunction

  // Value of an uppercase hex digit
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    return (c <= CH_9) ? c[3:0] : c[3:0] + 4'd9;
  endfunction

  // One byte of a body compare: name characters first, then '=' or NUL
  function automatic logic kw_step(input logic [7:0] b, input int unsigned i,
                                   input logic [KW_BITS-1:0] kw, input int unsigned klen);
    logic r;
    r = 1'b1;
    if (i == klen) begin
      r = (b == CH_EQ) || (b == CH_NUL);
    end else if (i < klen) begin
      r = (b == kw[8*(klen-1-i) +: 8]);
    end
    return r;
  endfunction

endpackage

[rtl/core/at_command_line_decoder.sv]
// Top level of the AT command line decoder: sequencer, result register, registers.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+----------------------------------
//  in_      | in        | in_valid / in_stall       | rx_byte
//  out_     | out       | out_valid / out_stall     | kind, data_byte, reg_addr, last
//  cfg_     | in        | APB psel/penable, pready  | host_id @0x0, remote_count @0x4
//
// A byte that does not end a line is stored. A CR leads to the decode state, which loads
// a command result if the result register is free (else ST_EMIT does), or then to ST_FWD,
// which forwards the line one byte a cycle while out_stall allows (single store read port).
// Reset is synchronous and clears control state; the line store needs no clearing. in_stall
// is high while a line is decoded, waits in ST_EMIT or is forwarded; out_stall holds the
// result register and pauses forward reads; input is taken while a loaded result waits.
module at_command_line_decoder
  import acd_pkg::*;
#(
  parameter int LINE_BYTES  = LINE_BYTES_DEF,
  parameter int BODY_MAX    = BODY_MAX_DEF,
  parameter int OPTIONS_MAX = OPTIONS_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [6:0]  out_reg_addr,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IW = $clog2(LINE_BYTES);
  localparam int LW = $clog2(LINE_BYTES + 1);

  state_t        state_r, state_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] rd_cnt_r, rd_cnt_nxt;
  logic          sup_r, sup_nxt;
  logic          pend_r, pend_nxt;
  logic          pend_last_r, pend_last_nxt;
  logic [6:0]    host_r, host_nxt;
  logic [6:0]    rcnt_r, rcnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  kind_t         out_kind_r, out_kind_nxt;
  logic [7:0]    out_data_r, out_data_nxt;
  logic [6:0]    out_addr_r, out_addr_nxt;
  logic          out_last_r, out_last_nxt;

  logic       in_acc, out_free, line_clear, rd_issue, move, sup_after, cfg_wr;
  logic [7:0] rd_data;
  dec_t       dec;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  acd_line_mem #(
    .LINE_BYTES (LINE_BYTES)
  ) u_mem (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (len_r[IW-1:0]),
    .wr_data (in_rx_byte),
    .rd_en   (rd_issue),
    .rd_addr (rd_cnt_r[IW-1:0]),
    .rd_data (rd_data)
  );

  acd_parse #(
    .LINE_BYTES  (LINE_BYTES),
    .BODY_MAX    (BODY_MAX),
    .OPTIONS_MAX (OPTIONS_MAX)
  ) u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .upd          (in_acc),
    .byte_in      (in_rx_byte),
    .idx          (len_r[IW-1:0]),
    .clear        (line_clear),
    .len          (len_r),
    .host_id      (host_r),
    .remote_count (rcnt_r),
    .dec          (dec)
  );

  // suppress flag as the decode leaves it
  always_comb begin
    sup_after = sup_r;
    if (dec.set_sup) begin
      sup_after = 1'b1;
    end else if (dec.clr_sup) begin
      sup_after = 1'b0;
    end
  end

  // sequencer, forward read pipeline and result register
  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    rd_cnt_nxt    = rd_cnt_r;
    sup_nxt       = sup_r;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    line_clear    = 1'b0;
    rd_issue      = 1'b0;
    move          = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_data_nxt  = out_data_r;
    out_addr_nxt  = out_addr_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_rx_byte == CH_CR) begin
            len_nxt   = len_r + LW'(1);
            state_nxt = ST_DECODE;
          end else if (len_r == LW'(LINE_BYTES - 1)) begin
            // full store without CR: drop the line
            len_nxt    = '0;
            line_clear = 1'b1;
          end else begin
            len_nxt = len_r + LW'(1);
          end
        end
      end
      ST_DECODE: begin
        sup_nxt = sup_after;
        if (dec.cmd) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = dec.kind;
            out_data_nxt  = dec.data;
            out_addr_nxt  = dec.addr;
            out_last_nxt  = 1'b1;
            len_nxt       = '0;
            line_clear    = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_EMIT;
          end
        end else if (!sup_after) begin
          rd_cnt_nxt = '0;
          state_nxt  = ST_FWD;
        end else begin
          len_nxt    = '0;
          line_clear = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = dec.kind;
          out_data_nxt  = dec.data;
          out_addr_nxt  = dec.addr;
          out_last_nxt  = 1'b1;
          len_nxt       = '0;
          line_clear    = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_FWD: begin
        // fetched byte moves to the result register when it is free
        move = pend_r && out_free;
        if (move) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_FWD;
          out_data_nxt  = rd_data;
          out_addr_nxt  = '0;
          out_last_nxt  = pend_last_r;
          pend_nxt      = 1'b0;
        end
        // next read once the read register will be empty
        if ((rd_cnt_r < len_r) && (!pend_r || move)) begin
          rd_issue      = 1'b1;
          pend_nxt      = 1'b1;
          pend_last_nxt = ((rd_cnt_r + LW'(1)) == len_r);
          rd_cnt_nxt    = rd_cnt_r + LW'(1);
        end else if ((rd_cnt_r == len_r) && (!pend_r || move)) begin
          len_nxt    = '0;
          rd_cnt_nxt = '0;
          line_clear = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // configuration writes
  always_comb begin
    host_nxt = host_r;
    rcnt_nxt = rcnt_r;
    if (cfg_wr) begin
      if (cfg_paddr[2] == REG_HOST_ID) begin
        host_nxt = cfg_pwdata[6:0];
      end else begin
        rcnt_nxt = cfg_pwdata[6:0];
      end
    end
  end

  // configuration reads, word aligned
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == REG_REMOTE_COUNT) begin
        cfg_prdata = {25'd0, rcnt_r};
      end else begin
        cfg_prdata = {25'd0, host_r};
      end
    end
  end

  assign cfg_pready = 1'b1;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      rd_cnt_r    <= '0;
      sup_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      host_r      <= HOST_ID_RST;
      rcnt_r      <= REMOTE_COUNT_RST;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      sup_r       <= sup_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      host_r      <= host_nxt;
      rcnt_r      <= rcnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_last_r <= pend_last_nxt;
    out_kind_r  <= out_kind_nxt;
    out_data_r  <= out_data_nxt;
    out_addr_r  <= out_addr_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_data_byte = out_data_r;
  assign out_reg_addr  = out_addr_r;
  assign out_last      = out_last_r;

  // a fetched byte only waits while forwarding
  a_pend_in_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == ST_FWD))
    else $error("forward byte pending outside forwarding");

  // a CR always leads to the decode cycle
  a_cr_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_rx_byte == CH_CR)) |=> (state_r == ST_DECODE))
    else $error("CR did not start a decode");

  // never more reads than stored bytes, and the store never overfills
  a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_cnt_r <= len_r) && (len_r <= LW'(LINE_BYTES)))
    else $error("line store bounds broken");

  // the result register is not overwritten while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r) && $stable(out_kind_r)))
    else $error("stalled result overwritten");

endmodule

[rtl/core/acd_line_mem.sv]
// Line store: single write port, one registered read port.
module acd_line_mem
  import acd_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BYTES_DEF,
  localparam int IW = $clog2(LINE_BYTES)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [LINE_BYTES];
  logic [7:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/acd_parse.sv]
// Running parse of the incoming line and decode of the command at line end.
module acd_parse
  import acd_pkg::*;
#(
  parameter int LINE_BYTES  = LINE_BYTES_DEF,
  parameter int BODY_MAX    = BODY_MAX_DEF,
  parameter int OPTIONS_MAX = OPTIONS_MAX_DEF,
  localparam int IW = $clog2(LINE_BYTES),
  localparam int LW = $clog2(LINE_BYTES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          upd,        // a byte is stored this cycle
  input  logic [7:0]    byte_in,
  input  logic [IW-1:0] idx,        // its place in the line
  input  logic          clear,      // start a fresh line
  input  logic [LW-1:0] len,
  input  logic [6:0]    host_id,
  input  logic [6:0]    remote_count,
  output dec_t          dec
);

  logic          found_r;
  logic [IW-1:0] eq_pos_r;
  logic          ok_on_r, ok_off_r, ok_ver_r, ok_sem_r;
  logic [7:0]    opt_r [NOPT];
  logic [IW-1:0] opt_pos;

  // place of this byte behind the first '='
  assign opt_pos = idx - eq_pos_r - IW'(1);

  // parse registers, updated as each byte comes in
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      found_r  <= 1'b0;
      eq_pos_r <= '0;
      ok_on_r  <= 1'b1;
      ok_off_r <= 1'b1;
      ok_ver_r <= 1'b1;
      ok_sem_r <= 1'b1;
      for (int k = 0; k < NOPT; k++) begin
        opt_r[k] <= CH_NUL;
      end
    end else if (upd) begin
      if (!found_r && (byte_in == CH_EQ)) begin
        found_r  <= 1'b1;
        eq_pos_r <= idx;
      end
      ok_on_r  <= ok_on_r  && kw_step(byte_in, int'(idx), KW_ON, KW_ON_LEN);
      ok_off_r <= ok_off_r && kw_step(byte_in, int'(idx), KW_OFF, KW_OFF_LEN);
      ok_ver_r <= ok_ver_r && kw_step(byte_in, int'(idx), KW_VERSION, KW_VERSION_LEN);
      ok_sem_r <= ok_sem_r && kw_step(byte_in, int'(idx), KW_SEMREG, KW_SEMREG_LEN);
      for (int k = 0; k < NOPT; k++) begin
        if (found_r && (int'(opt_pos) == k)) begin
          opt_r[k] <= byte_in;
        end
      end
    end
  end

  // decode from the finished parse
  logic       eq_ok, on_hit, ver_hit, sem_hit, digits_ok, sem_addr_ok;
  logic [6:0] h_num, r_num;

  always_comb begin
    eq_ok = found_r && (int'(eq_pos_r) <= BODY_MAX)
            && (int'(len) <= BODY_MAX + OPTIONS_MAX + 1);
    on_hit = eq_ok && ((ok_on_r && (int'(eq_pos_r) >= KW_ON_LEN))
                    || (ok_off_r && (int'(eq_pos_r) >= KW_OFF_LEN)));
    ver_hit = eq_ok && !on_hit && ok_ver_r && (int'(eq_pos_r) >= KW_VERSION_LEN);
    sem_hit = eq_ok && !on_hit && !ver_hit && ok_sem_r
              && (int'(eq_pos_r) >= KW_SEMREG_LEN);

    // at+on / at+off = DD,DD
    digits_ok = (opt_r[2] == CH_COMMA) && is_dec(opt_r[0]) && is_dec(opt_r[1])
                && is_dec(opt_r[3]) && is_dec(opt_r[4]);
    h_num = 7'({3'b000, opt_r[0][3:0]} * 7'd10) + {3'b000, opt_r[1][3:0]};
    r_num = 7'({3'b000, opt_r[3][3:0]} * 7'd10) + {3'b000, opt_r[4][3:0]};

    sem_addr_ok = (opt_r[0] >= CH_0) && (opt_r[0] <= CH_7) && is_hex(opt_r[1]);

    dec         = '0;
    dec.kind    = KIND_FWD;
    dec.clr_sup = on_hit && digits_ok && (h_num == host_id)
                  && (r_num >= 7'd1) && (r_num <= remote_count);
    dec.set_sup = ver_hit || sem_hit;

    if (ver_hit && (opt_r[0] == CH_QUERY)) begin
      dec.cmd  = 1'b1;
      dec.kind = KIND_VERSION;
    end else if (sem_hit && sem_addr_ok) begin
      dec.cmd = 1'b1;
      if (opt_r[2] == CH_COMMA) begin
        if (is_hex(opt_r[3]) && is_hex(opt_r[4])) begin
          dec.kind = KIND_WR_OK;
          dec.data = {hex_val(opt_r[3]), hex_val(opt_r[4])};
          dec.addr = {opt_r[0][2:0], hex_val(opt_r[1])};
        end else begin
          dec.kind = KIND_WR_REJ;
        end
      end else begin
        dec.kind = KIND_RD;
        dec.addr = {opt_r[0][2:0], hex_val(opt_r[1])};
      end
    end
  end

endmodule

[tb/sv/at_command_line_decoder_test.sv]
// Self-checking testbench for the AT command line decoder: directed lines, then random traffic.
`timescale 1ns / 100ps

module at_command_line_decoder_test;
  import acd_pkg::*;

  localparam int LATENCY_CYCLES = 2 * LINE_BYTES_DEF;
  localparam int MAX_REPORTS    = 40;
  localparam int PHASE_BYTES    = 12;
  localparam int N_PHASES       = 6;
  localparam int N_ROWS         = 30;
  localparam logic [2:0] HOST_ADDR   = {REG_HOST_ID, 2'b00};
  localparam logic [2:0] REMOTE_ADDR = {REG_REMOTE_COUNT, 2'b00};

  // One result item as the block sends it
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [6:0] addr;
    logic       last;
  } line_result_t;

  // One directed line; CR is appended unless the line is left open
  typedef struct {
    string        text;
    bit           open;
    int           poke_at;
    logic [7:0]   poke_val;
    bit           typed;
    line_result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic [6:0]  out_reg_addr;
  logic        out_last;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Predictor state
  logic [7:0]   line_buf [LINE_BYTES_DEF];
  int           line_len;
  bit           fwd_muted;
  logic [6:0]   host_num;
  logic [6:0]   remote_max;
  line_result_t step_out [$];
  line_result_t awaited_results [$];

  logic [7:0] line_q [$];
  int         fault_count = 0;
  bit         calm = 1'b0;
  int         stall_left = 0;

  int phase_host   [N_PHASES] = '{0, 99, 99, -1, 0, -1};
  int phase_remote [N_PHASES] = '{99, 0, 99, -1, 1, -1};

  stim_row_t dir_rows [N_ROWS] = '{
    '{"at+version=?",         1'b0, -1, 8'h00, 1'b1, '{KIND_VERSION, 8'h00, 7'h00, 1'b1}},
    '{"hello",                1'b0, -1, 8'h00, 1'b0, '0},
    '{"at+on=01,04",          1'b0, -1, 8'h00, 1'b0, '0},
    '{"",                     1'b0, -1, 8'h00, 1'b0, '0},
    '{"?x",                   1'b0,  0, 8'hFF, 1'b0, '0},
    '{"at+semreg=7F,FF",      1'b0, -1, 8'h00, 1'b1, '{KIND_WR_OK, 8'hFF, 7'h7F, 1'b1}},
    '{"at+off=01,01",         1'b0, -1, 8'h00, 1'b0, '0},
    '{"at+semreg=00,00",      1'b0, -1, 8'h00, 1'b1, '{KIND_WR_OK, 8'h00, 7'h00, 1'b1}},
    '{"at+semreg=3A",         1'b0, -1, 8'h00, 1'b1, '{KIND_RD, 8'h00, 7'h3A, 1'b1}},
    '{"at+semreg=12,G0",      1'b0, -1, 8'h00, 1'b1, '{KIND_WR_REJ, 8'h00, 7'h00, 1'b1}},
    '{"at+off=01,04",         1'b0, -1, 8'h00, 1'b0, '0},
    '{"at+semreg=1a,00",      1'b0, -1, 8'h00, 1'b0, '0},
    '{"at+semreg=8A",         1'b0, -1, 8'h00, 1'b0, '0},
    '{"at+on=01,05",          1'b0, -1, 8'h00, 1'b0, '0},
    '{"at+on=02,01",          1'b0, -1, 8'h00, 1'b0, '0},
    '{"at+on=01,00",          1'b0, -1, 8'h00, 1'b0, '0},
    '{"at+on?zz=01,04",       1'b0,  5, 8'h00, 1'b0, '0},
    '{"at+version=x",         1'b0, -1, 8'h00, 1'b0, '0},
    '{"at+off=01,03",         1'b0, -1, 8'h00, 1'b0, '0},
    '{"at+versions=?",        1'b0, -1, 8'h00, 1'b0, '0},
    '{"at+version?12=?",      1'b0, 10, 8'h00, 1'b0, '0},
    '{"at+semreg=3A,5F    ",  1'b0, -1, 8'h00, 1'b0, '0},
    '{"0123456789abcdefghij", 1'b1, -1, 8'h00, 1'b0, '0},
    '{"",                     1'b0, -1, 8'h00, 1'b0, '0},
    '{"at+semreg=3A,5F   ",   1'b0, -1, 8'h00, 1'b1, '{KIND_WR_OK, 8'h5F, 7'h3A, 1'b1}},
    '{"at+semreg=3",          1'b0, -1, 8'h00, 1'b0, '0},
    '{"at+version=?abc",      1'b0, -1, 8'h00, 1'b1, '{KIND_VERSION, 8'h00, 7'h00, 1'b1}},
    '{"at+on=01,04,9",        1'b0, -1, 8'h00, 1'b0, '0},
    '{"at+semreg=3A,F",       1'b0, -1, 8'h00, 1'b1, '{KIND_WR_REJ, 8'h00, 7'h00, 1'b1}},
    '{"a=b",                  1'b0, -1, 8'h00, 1'b0, '0}
  };

  at_command_line_decoder uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_data_byte (out_data_byte),
    .out_reg_addr  (out_reg_addr),
    .out_last      (out_last),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready)
  );

  always #5 clk = ~clk;

  // Run limit
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------- predictor ----------------

  function automatic void reset_model();
    line_len   = 0;
    fwd_muted  = 1'b0;
    host_num   = HOST_ID_RST;
    remote_max = REMOTE_COUNT_RST;
  endfunction

  // -1 when not a decimal digit
  function automatic int dec_digit(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    return -1;
  endfunction

  // uppercase only; -1 when not a hex digit
  function automatic int hex_digit(input logic [7:0] c);
    if (c >= CH_A && c <= CH_F) return int'(c - CH_A) + 10;
    return dec_digit(c);
  endfunction

  // body equals the name, a NUL straight after the name also ends it
  function automatic bit body_named(input int eq, input logic [KW_BITS-1:0] kw, input int klen);
    int k;
    if (eq < klen) return 1'b0;
    for (k = 0; k < klen; k++)
      if (line_buf[k] != kw[8*(klen-1-k) +: 8]) return 1'b0;
    return (eq == klen) || (line_buf[klen] == CH_NUL);
  endfunction

  function automatic logic [7:0] option_byte(input int eq, input int k);
    int n;
    n = line_len - eq - 1;
    if (k >= n || k >= OPTIONS_MAX_DEF) return CH_NUL;
    // too many options: the last kept slot reads as empty
    if (n > OPTIONS_MAX_DEF && k == OPTIONS_MAX_DEF - 1) return CH_NUL;
    return line_buf[eq + 1 + k];
  endfunction

  // command decode of a finished line; may change the mute flag
  function automatic void decode_command(output bit made, output line_result_t res);
    int i, eq, h, r, a_hi, a_lo;
    bit found;
    logic [7:0] opt [NOPT];
    made = 1'b0;
    res = '0;
    if (line_len > BODY_MAX_DEF + OPTIONS_MAX_DEF + 1) return;
    found = 1'b0;
    eq = 0;
    for (i = 0; i < line_len; i++) begin
      if (!found && line_buf[i] == CH_EQ) begin
        eq = i;
        found = 1'b1;
      end
    end
    if (!found || eq > BODY_MAX_DEF) return;
    for (i = 0; i < NOPT; i++) opt[i] = option_byte(eq, i);

    // host on/off: clears the mute when host and remote numbers fit
    if (body_named(eq, KW_ON, KW_ON_LEN) || body_named(eq, KW_OFF, KW_OFF_LEN)) begin
      if (opt[2] == CH_COMMA && dec_digit(opt[0]) >= 0 && dec_digit(opt[1]) >= 0 &&
          dec_digit(opt[3]) >= 0 && dec_digit(opt[4]) >= 0) begin
        h = dec_digit(opt[0]) * 10 + dec_digit(opt[1]);
        r = dec_digit(opt[3]) * 10 + dec_digit(opt[4]);
        if (h == host_num && r >= 1 && r <= remote_max) fwd_muted = 1'b0;
      end
      return;
    end

    if (body_named(eq, KW_VERSION, KW_VERSION_LEN)) begin
      fwd_muted = 1'b1;
      if (opt[0] == CH_QUERY) begin
        made = 1'b1;
        res.kind = KIND_VERSION;
      end
      return;
    end

    // register access: address digit 0..7 then a hex digit
    if (body_named(eq, KW_SEMREG, KW_SEMREG_LEN)) begin
      fwd_muted = 1'b1;
      a_hi = dec_digit(opt[0]);
      a_lo = hex_digit(opt[1]);
      if (a_hi >= 0 && a_hi <= 7 && a_lo >= 0) begin
        made = 1'b1;
        if (opt[2] != CH_COMMA) begin
          res.kind = KIND_RD;
          res.addr = 7'(a_hi * 16 + a_lo);
        end else if (hex_digit(opt[3]) >= 0 && hex_digit(opt[4]) >= 0) begin
          res.kind = KIND_WR_OK;
          res.addr = 7'(a_hi * 16 + a_lo);
          res.data = 8'(hex_digit(opt[3]) * 16 + hex_digit(opt[4]));
        end else begin
          res.kind = KIND_WR_REJ;
        end
      end
    end
  endfunction

  // one received byte into the line; results land in step_out
  function automatic void line_decode_byte(input logic [7:0] b);
    bit made;
    line_result_t res;
    int i;
    step_out.delete();
    if (line_len < LINE_BYTES_DEF) begin
      line_buf[line_len] = b;
      line_len++;
    end
    if (line_buf[line_len - 1] == CH_CR) begin
      decode_command(made, res);
      if (made) begin
        res.last = 1'b1;
        step_out.push_back(res);
      end else if (!fwd_muted) begin
        for (i = 0; i < line_len; i++)
          step_out.push_back(line_result_t'{KIND_FWD, line_buf[i], 7'h00, i == line_len - 1});
      end
      line_len = 0;
    end else if (line_len >= LINE_BYTES_DEF) begin
      // full store without CR: line dropped
      line_len = 0;
    end
  endfunction

  // ---------------- drivers ----------------

  // one input item; the expectation is queued at the accepting edge
  task automatic send_byte(input logic [7:0] b, input bit typed, input line_result_t want);
    int i;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    line_decode_byte(b);
    if (typed) begin
      awaited_results.push_back(want);
    end else begin
      for (i = 0; i < step_out.size(); i++) awaited_results.push_back(step_out[i]);
    end
  endtask

  // a typed expectation stands for the result of the last byte only
  task automatic send_line(input bit typed, input line_result_t want);
    int i;
    for (i = 0; i < line_q.size(); i++)
      send_byte(line_q[i], typed && (i == line_q.size() - 1), want);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == HOST_ADDR) host_num = value[6:0];
    else remote_max = value[6:0];
  endtask

  // wait for every result, then let a silent line finish
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (LATENCY_CYCLES) @(posedge clk);
  endtask

  // ---------------- random lines ----------------

  function automatic logic [7:0] rand_print();
    return 8'($urandom_range(32'h20, 32'h7E));
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(0, 15);
    return (v < 10) ? 8'(CH_0 + v) : 8'(CH_A + v - 10);
  endfunction

  function automatic void add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic void add_dec2(input int v);
    line_q.push_back(8'(CH_0 + v / 10));
    line_q.push_back(8'(CH_0 + v % 10));
  endfunction

  // mostly well-formed commands with random content, some noise and broken lines
  task automatic make_line();
    int n, i;
    bit close;
    logic [7:0] b;
    line_q.delete();
    close = 1'b1;
    case ($urandom_range(0, 11))
      0, 1: begin
        if ($urandom_range(0, 1)) add_text("at+on=");
        else add_text("at+off=");
        add_dec2(($urandom_range(0, 3) != 0) ? int'(host_num) : int'($urandom_range(0, 99)));
        line_q.push_back(CH_COMMA);
        if (remote_max > 0 && $urandom_range(0, 3) != 0) add_dec2($urandom_range(1, remote_max));
        else add_dec2($urandom_range(0, 99));
      end
      2: begin
        add_text("at+version=");
        line_q.push_back(($urandom_range(0, 3) != 0) ? CH_QUERY : rand_print());
        repeat ($urandom_range(0, 6)) line_q.push_back(rand_print());
      end
      3, 4: begin
        add_text("at+semreg=");
        line_q.push_back(($urandom_range(0, 7) != 0) ? 8'(CH_0 + $urandom_range(0, 7))
                                                      : rand_print());
        line_q.push_back(($urandom_range(0, 7) != 0) ? rand_hex_char() : rand_print());
        if ($urandom_range(0, 2) != 0) begin
          line_q.push_back(CH_COMMA);
          repeat (2) line_q.push_back(($urandom_range(0, 3) != 0) ? rand_hex_char() : rand_print());
        end
      end
      5, 6, 7: begin
        repeat ($urandom_range(0, 17)) line_q.push_back(rand_print());
      end
      8: begin
        // at or just past the decode length limit
        n = $urandom_range(18, 19);
        if ($urandom_range(0, 1)) add_text("at+version=?");
        while (line_q.size() < n) line_q.push_back(rand_print());
      end
      9: begin
        // store fills without CR
        close = 1'b0;
        repeat (LINE_BYTES_DEF) begin
          b = 8'($urandom_range(0, 255));
          line_q.push_back((b == CH_CR) ? CH_NUL : b);
        end
      end
      10: begin
        close = 1'b0;
        repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        case ($urandom_range(0, 2))
          0: begin
            // NUL ends the body early
            add_text("at+on");
            line_q.push_back(CH_NUL);
            line_q.push_back(rand_print());
            line_q.push_back(CH_EQ);
            add_dec2(host_num);
            line_q.push_back(CH_COMMA);
            add_dec2($urandom_range(0, 9));
          end
          1: begin
            // '=' around the body limit
            add_text("at+semreg");
            repeat ($urandom_range(2, 5)) line_q.push_back(rand_print());
            line_q.push_back(CH_EQ);
            add_text("3A");
          end
          default: begin
            // short or overlong option list
            add_text("at+semreg=");
            n = $urandom_range(0, 9);
            for (i = 0; i < n; i++) line_q.push_back((i % 3 == 2) ? CH_COMMA : rand_hex_char());
          end
        endcase
      end
    endcase
    if (close) line_q.push_back(CH_CR);
  endtask

  // ---------------- result side ----------------

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (!calm && stall_left == 0 && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 5);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void report(input string field, input int want_v, input int got_v);
    fault_count++;
    if (fault_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
  endfunction

  // compare each accepted result item with the oldest expectation
  always @(posedge clk) begin
    line_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("%0t: unexpected item, expected none, actual kind %0d data %h addr %h last %b",
                   $time, out_kind, out_data_byte, out_reg_addr, out_last);
      end else begin
        want = awaited_results.pop_front();
        if (out_kind != want.kind) report("kind", int'(want.kind), int'(out_kind));
        if (out_data_byte != want.data) report("data_byte", int'(want.data), int'(out_data_byte));
        if (out_reg_addr != want.addr) report("reg_addr", int'(want.addr), int'(out_reg_addr));
        if (out_last != want.last) report("last", int'(want.last), int'(out_last));
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin
    int r, p, i, sent;
    stim_row_t row;
    reset_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed lines at reset register values
    for (r = 0; r < N_ROWS; r++) begin
      row = dir_rows[r];
      line_q.delete();
      for (i = 0; i < row.text.len(); i++) line_q.push_back(row.text[i]);
      if (row.poke_at >= 0) line_q[row.poke_at] = row.poke_val;
      if (!row.open) line_q.push_back(CH_CR);
      send_line(row.typed, row.want);
    end

    // random phases, one register setting each; the last one without idling
    for (p = 0; p < N_PHASES; p++) begin
      settle();
      write_reg(HOST_ADDR, (phase_host[p] < 0) ? $urandom_range(0, 99) : phase_host[p]);
      write_reg(REMOTE_ADDR, (phase_remote[p] < 0) ? $urandom_range(0, 99) : phase_remote[p]);
      calm = (p == N_PHASES - 1);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        make_line();
        send_line(1'b0, '0);
        sent += line_q.size();
      end
    end

    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (LATENCY_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
